### sv/lsce_pkg.sv
// shared types and codes for the load state control engine
package lsce_pkg;

   typedef enum logic [1:0] {
      LS_UNLOADED = 2'd0,
      LS_LOADED   = 2'd1,
      LS_LOADING  = 2'd2,
      LS_ERROR    = 2'd3
   } load_state_type;

   typedef enum logic [1:0] {
      REGION_NONE   = 2'd0,
      REGION_EEPROM = 2'd1,
      REGION_RAM    = 2'd2
   } region_type;

   localparam logic [7:0] CTL_NONE     = 8'd0;
   localparam logic [7:0] CTL_LOAD     = 8'd1;
   localparam logic [7:0] CTL_COMPLETE = 8'd2;
   localparam logic [7:0] CTL_DATA     = 8'd3;
   localparam logic [7:0] CTL_UNLOAD   = 8'd4;

   localparam logic [7:0] SEG_TABLE    = 8'd2;
   localparam logic [7:0] SEG_POINTERS = 8'd5;
   localparam logic [7:0] SEG_LAST     = 8'd5;

   localparam logic [1:0] OBJ_APPLICATION = 2'd3;

   localparam int         CSR_ADDR_W = 5;
   localparam logic [2:0] REG_OBJECT_KIND  = 3'd0;
   localparam logic [2:0] REG_EEPROM_START = 3'd1;
   localparam logic [2:0] REG_EEPROM_END   = 3'd2;
   localparam logic [2:0] REG_RAM_START    = 3'd3;
   localparam logic [2:0] REG_RAM_END      = 3'd4;

   localparam logic [15:0] EEPROM_START_RST = 16'd256;
   localparam logic [15:0] EEPROM_END_RST   = 16'd1280;
   localparam logic [15:0] RAM_START_RST    = 16'd0;
   localparam logic [15:0] RAM_END_RST      = 16'd256;

   typedef struct packed {
      logic [1:0]  object_kind;
      logic [15:0] eeprom_start;
      logic [15:0] eeprom_end;
      logic [15:0] ram_start;
      logic [15:0] ram_end;
   } cfg_type;

   typedef struct packed {
      logic [7:0] control_code;
      logic [7:0] segment_type;
      logic [7:0] rec_byte2;
      logic [7:0] rec_byte3;
      logic [7:0] rec_byte4;
      logic [7:0] rec_byte5;
      logic [7:0] rec_byte6;
      logic [7:0] rec_byte7;
      logic [7:0] rec_byte8;
      logic [7:0] rec_byte9;
   } rec_type;

   typedef struct packed {
      load_state_type reply_state;
      logic [15:0]    table_address_out;
      region_type     table_region;
      logic [15:0]    table_offset;
      logic [7:0]     pei_type_out;
      logic [15:0]    manufacturer_out;
      logic [15:0]    device_type_out;
      logic [7:0]     version_out;
      logic [15:0]    segment0_out;
      logic [15:0]    segment1_out;
   } result_type;

endpackage

### sv/lsce_csr.sv
// apb register file for object kind and memory windows
module lsce_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lsce_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output lsce_pkg::cfg_type               cfg
);
   import lsce_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.object_kind  <= 2'd0;
         cfg_ff.eeprom_start <= EEPROM_START_RST;
         cfg_ff.eeprom_end   <= EEPROM_END_RST;
         cfg_ff.ram_start    <= RAM_START_RST;
         cfg_ff.ram_end      <= RAM_END_RST;
      end else if (wr_en) begin
         case (reg_index)
            REG_OBJECT_KIND:  cfg_ff.object_kind  <= pwdata[1:0];
            REG_EEPROM_START: cfg_ff.eeprom_start <= pwdata[15:0];
            REG_EEPROM_END:   cfg_ff.eeprom_end   <= pwdata[15:0];
            REG_RAM_START:    cfg_ff.ram_start    <= pwdata[15:0];
            REG_RAM_END:      cfg_ff.ram_end      <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_OBJECT_KIND:  prdata = {30'd0, cfg_ff.object_kind};
         REG_EEPROM_START: prdata = {16'd0, cfg_ff.eeprom_start};
         REG_EEPROM_END:   prdata = {16'd0, cfg_ff.eeprom_end};
         REG_RAM_START:    prdata = {16'd0, cfg_ff.ram_start};
         REG_RAM_END:      prdata = {16'd0, cfg_ff.ram_end};
         default:          prdata = 32'd0;
      endcase
   end

endmodule

### sv/lsce_region.sv
// maps a table address onto the eeprom or ram window and its offset
module lsce_region (
   input  logic [15:0]          table_address,
   input  lsce_pkg::cfg_type    cfg,
   output lsce_pkg::region_type region,
   output logic [15:0]          offset
);
   import lsce_pkg::*;

   logic in_eeprom;
   logic in_ram;

   // an empty or inverted window never matches
   assign in_eeprom = (table_address >= cfg.eeprom_start) && (table_address < cfg.eeprom_end);
   assign in_ram    = (table_address >= cfg.ram_start) && (table_address < cfg.ram_end);

   always_comb begin
      if (in_eeprom) begin
         region = REGION_EEPROM;
         offset = table_address - cfg.eeprom_start;
      end else if (in_ram) begin
         region = REGION_RAM;
         offset = table_address - cfg.ram_start;
      end else begin
         region = REGION_NONE;
         offset = 16'd0;
      end
   end

endmodule

### sv/lsce_core.sv
// load state and stored identity words, updated once per record
module lsce_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  lsce_pkg::cfg_type    cfg,
   input  lsce_pkg::rec_type    rec,
   output lsce_pkg::result_type result
);
   import lsce_pkg::*;

   load_state_type ls_ff, ls_in;
   logic [15:0]    ta_ff, ta_in;
   logic [7:0]     pei_ff, pei_in;
   logic [15:0]    mfr_ff, mfr_in;
   logic [15:0]    dev_ff, dev_in;
   logic [7:0]     ver_ff, ver_in;
   logic [15:0]    seg0_ff, seg0_in;
   logic [15:0]    seg1_ff, seg1_in;
   logic           bad_segment;
   logic [15:0]    pointer_table;
   region_type     region;
   logic [15:0]    offset;

   assign bad_segment   = (rec.control_code == CTL_DATA) && (rec.segment_type > SEG_LAST);
   assign pointer_table = {rec.rec_byte4, rec.rec_byte5};

   // next state
   always_comb begin
      ls_in   = ls_ff;
      ta_in   = ta_ff;
      pei_in  = pei_ff;
      mfr_in  = mfr_ff;
      dev_in  = dev_ff;
      ver_in  = ver_ff;
      seg0_in = seg0_ff;
      seg1_in = seg1_ff;
      case (rec.control_code)
         CTL_NONE, CTL_UNLOAD: ls_in = LS_UNLOADED;
         CTL_LOAD:             ls_in = LS_LOADING;
         CTL_COMPLETE:         ls_in = LS_LOADED;
         CTL_DATA: begin
            if (!bad_segment) begin
               ls_in = LS_LOADING;
               if (rec.segment_type == SEG_TABLE) begin
                  ta_in = {rec.rec_byte2, rec.rec_byte3};
                  if (cfg.object_kind == OBJ_APPLICATION) begin
                     pei_in = rec.rec_byte4;
                     mfr_in = {rec.rec_byte5, rec.rec_byte6};
                     dev_in = {rec.rec_byte7, rec.rec_byte8};
                     ver_in = rec.rec_byte9;
                  end
               end else if (rec.segment_type == SEG_POINTERS) begin
                  // a zero table word leaves the table address alone
                  if (pointer_table != 16'd0) begin
                     ta_in = pointer_table;
                  end
                  seg0_in = {rec.rec_byte6, rec.rec_byte7};
                  seg1_in = {rec.rec_byte8, rec.rec_byte9};
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ls_ff   <= LS_UNLOADED;
         ta_ff   <= 16'd0;
         pei_ff  <= 8'd0;
         mfr_ff  <= 16'd0;
         dev_ff  <= 16'd0;
         ver_ff  <= 8'd0;
         seg0_ff <= 16'd0;
         seg1_ff <= 16'd0;
      end else if (step) begin
         ls_ff   <= ls_in;
         ta_ff   <= ta_in;
         pei_ff  <= pei_in;
         mfr_ff  <= mfr_in;
         dev_ff  <= dev_in;
         ver_ff  <= ver_in;
         seg0_ff <= seg0_in;
         seg1_ff <= seg1_in;
      end
   end

   lsce_region u_region (
      .table_address (ta_in),
      .cfg           (cfg),
      .region        (region),
      .offset        (offset)
   );

   // result word
   always_comb begin
      result.reply_state       = bad_segment ? LS_ERROR : ls_in;
      result.table_address_out = ta_in;
      result.table_region      = region;
      result.table_offset      = offset;
      result.pei_type_out      = pei_in;
      result.manufacturer_out  = mfr_in;
      result.device_type_out   = dev_in;
      result.version_out       = ver_in;
      result.segment0_out      = seg0_in;
      result.segment1_out      = seg1_in;
   end

endmodule

### sv/load_state_control_engine.sv
// top level: input register, state update, result register, apb registers
//
//  port group   dir   handshake            carries
//  req_*        in    req_valid/req_ready  control code, segment type, record bytes 2..9
//  rsp_*        out   rsp_valid/rsp_ready  reply state, table address/region/offset, ids
//  apb          in    psel/penable/pready  object kind and the two memory windows
//
// one word per cycle while the result is taken; a word is captured in the input
// register and then moves on to the result register.
// the state update and window compare sit between the two registers.
// reset clears the load state, stored words, valid flags and apb registers to their defaults.
// a stalled result holds the input register; a new word still enters while
// the result waits only if the input register is free.
module load_state_control_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_control_code,
   input  logic [7:0]  req_segment_type,
   input  logic [7:0]  req_rec_byte2,
   input  logic [7:0]  req_rec_byte3,
   input  logic [7:0]  req_rec_byte4,
   input  logic [7:0]  req_rec_byte5,
   input  logic [7:0]  req_rec_byte6,
   input  logic [7:0]  req_rec_byte7,
   input  logic [7:0]  req_rec_byte8,
   input  logic [7:0]  req_rec_byte9,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_reply_state,
   output logic [15:0] rsp_table_address_out,
   output logic [1:0]  rsp_table_region,
   output logic [15:0] rsp_table_offset,
   output logic [7:0]  rsp_pei_type_out,
   output logic [15:0] rsp_manufacturer_out,
   output logic [15:0] rsp_device_type_out,
   output logic [7:0]  rsp_version_out,
   output logic [15:0] rsp_segment0_out,
   output logic [15:0] rsp_segment1_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lsce_pkg::*;

   logic       in_valid_ff;
   rec_type    rec_ff;
   logic       out_valid_ff;
   result_type res_ff;
   result_type res_in;
   cfg_type    cfg;
   logic       advance;
   logic       req_take;

   lsce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // word moves to the result register when that register is empty or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rec_ff.control_code <= req_control_code;
         rec_ff.segment_type <= req_segment_type;
         rec_ff.rec_byte2    <= req_rec_byte2;
         rec_ff.rec_byte3    <= req_rec_byte3;
         rec_ff.rec_byte4    <= req_rec_byte4;
         rec_ff.rec_byte5    <= req_rec_byte5;
         rec_ff.rec_byte6    <= req_rec_byte6;
         rec_ff.rec_byte7    <= req_rec_byte7;
         rec_ff.rec_byte8    <= req_rec_byte8;
         rec_ff.rec_byte9    <= req_rec_byte9;
      end
   end

   lsce_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg),
      .rec    (rec_ff),
      .result (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_reply_state       = res_ff.reply_state;
   assign rsp_table_address_out = res_ff.table_address_out;
   assign rsp_table_region      = res_ff.table_region;
   assign rsp_table_offset      = res_ff.table_offset;
   assign rsp_pei_type_out      = res_ff.pei_type_out;
   assign rsp_manufacturer_out  = res_ff.manufacturer_out;
   assign rsp_device_type_out   = res_ff.device_type_out;
   assign rsp_version_out       = res_ff.version_out;
   assign rsp_segment0_out      = res_ff.segment0_out;
   assign rsp_segment1_out      = res_ff.segment1_out;

endmodule
